// File: hw/rtl/wld_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wld_pkg
// Shared types, sizes and helpers for the weighted least-load dispatcher.
// ----------------------------------------------------------------------------
package wld_pkg;

   // Sizes
   localparam int NUM_PROCS  = 4;
   localparam int WL_W       = 24;                      // stored workload width
   localparam int PIDX_W     = $clog2(NUM_PROCS);       // processor index width
   localparam int PWR_W      = 8;                       // power / threshold width
   localparam int WEIGHT_W   = 16;
   localparam int TAG_W      = 8;
   localparam int PROC_OUT_W = 2;                       // chosen_proc field width
   localparam int RSP_WL_W   = 24;                      // new_workload field width
   localparam int PROD_W     = WL_W + PWR_W;            // workload x power
   localparam int PP_W       = 2 * PWR_W;               // power x power
   localparam int LIM_W      = PWR_W + PP_W;            // threshold x power x power
   localparam int CMP_W      = (PROD_W > LIM_W) ? PROD_W : LIM_W;
   localparam int SUM_W      = ((WL_W > WEIGHT_W) ? WL_W : WEIGHT_W) + 1;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = PWR_W;
   localparam logic [CSR_ADDR_W-1:0] CSR_POWER_0   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_THRESHOLD = 3'd4;

   localparam logic [PWR_W-1:0] THRESHOLD_RESET = 8'd2;

   // Payload of one beat on each channel
   typedef struct packed {
      logic [WEIGHT_W-1:0] task_weight;
      logic [TAG_W-1:0]    task_tag;
   } req_type;

   typedef struct packed {
      logic [PROC_OUT_W-1:0] chosen_proc;
      logic                  by_round_robin;
      logic [RSP_WL_W-1:0]   new_workload;
      logic [TAG_W-1:0]      tag_out;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;   // latch request, register cross products
      logic rank;      // find lowest and second-lowest load
      logic decide;    // threshold test, pick processor
      logic commit;    // update workload and pointer, load response
   } cmd_type;

   // Power reset values per processor
   function automatic logic [PWR_W-1:0] power_reset(input int idx);
      logic [PWR_W-1:0] val;
      case (idx)
         0: val = 8'd2;
         1: val = 8'd1;
         2: val = 8'd3;
         3: val = 8'd2;
         default: val = 8'd1;
      endcase
      return val;
   endfunction

   // A power of zero counts as one
   function automatic logic [PWR_W-1:0] eff_power(input logic [PWR_W-1:0] p);
      return (p == '0) ? PWR_W'(1) : p;
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/weighted_least_load_dispatcher.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_least_load_dispatcher
// Assigns each task to one of four processors by least weighted load, with
// round-robin fallback when the two lowest loads are within the threshold.
// ----------------------------------------------------------------------------
// On the accept edge of each task the workload-by-power cross products are
// registered; then the rank state ranks the loads, the decide state compares
// the load gap with threshold x power x power, and the write state commits the
// saturated workload and loads the response register. The next task can be
// accepted in the cycle after commit, so only one task is in flight at a time;
// the chain is set by the dependence of each decision on the previous
// workload update. Commit waits while an earlier response is still untaken.
// Configuration registers (index 0..3 power, 4 threshold) are written with
// csr_we and should only change while no task is in flight.
module weighted_least_load_dispatcher (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire wld_pkg::req_type                req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output wld_pkg::rsp_type                     rsp_data,
   input  wire logic                            csr_we,
   input  wire logic [wld_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  wire logic [wld_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   wld_pkg::cmd_type cmd;

   // Sequencer
   wld_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // Datapath
   wld_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// File: hw/rtl/wld_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wld_ctrl
// Sequencer: steps one task through rank, decide and commit, and owns the
// handshake flags of both channels.
// ----------------------------------------------------------------------------
module wld_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output wld_pkg::cmd_type       cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_RANK   = 2'd1;
   localparam logic [1:0] ST_DECIDE = 2'd2;
   localparam logic [1:0] ST_WRITE  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Commands
   always_comb begin
      cmd.capture = (state_ff == ST_IDLE) && req_valid;
      cmd.rank    = (state_ff == ST_RANK);
      cmd.decide  = (state_ff == ST_DECIDE);
      cmd.commit  = (state_ff == ST_WRITE) && slot_free;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_RANK;
         ST_RANK:   state_in = ST_DECIDE;
         ST_DECIDE: state_in = ST_WRITE;
         ST_WRITE:  if (slot_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Response valid: set on commit, cleared when the beat is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.commit) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/wld_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wld_dp
// Datapath: configuration registers, workloads, round-robin pointer, cross
// products, ranking, threshold test and saturating workload update.
// ----------------------------------------------------------------------------
module wld_dp (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire wld_pkg::cmd_type                    cmd,
   input  wire wld_pkg::req_type                    req_data,
   input  wire logic                                csr_we,
   input  wire logic [wld_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  wire logic [wld_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output wld_pkg::rsp_type                         rsp_data
);

   localparam int N = wld_pkg::NUM_PROCS;
   localparam logic [wld_pkg::WL_W-1:0] WL_ALL_ONES = '1;

   // Configuration and state
   logic [wld_pkg::PWR_W-1:0]    pwr_ff [N];
   logic [wld_pkg::PWR_W-1:0]    thr_ff;
   logic [wld_pkg::WL_W-1:0]     wl_ff [N];
   logic [wld_pkg::PIDX_W-1:0]   rr_ff;

   // Per-task registers
   logic [wld_pkg::WEIGHT_W-1:0] weight_ff;
   logic [wld_pkg::TAG_W-1:0]    tag_ff;
   logic [wld_pkg::PROD_W-1:0]   prod_ff [N][N];
   logic [wld_pkg::PROD_W-1:0]   prod_in [N][N];
   logic [wld_pkg::PP_W-1:0]     pp_ff [N][N];
   logic [wld_pkg::PP_W-1:0]     pp_in [N][N];
   logic [wld_pkg::PIDX_W-1:0]   first_ff, first_in;
   logic [wld_pkg::PIDX_W-1:0]   second_ff, second_in;
   logic [wld_pkg::PIDX_W-1:0]   chosen_ff, chosen_in;
   logic                         rr_sel_ff, rr_sel_in;
   wld_pkg::rsp_type             rsp_ff, rsp_in;

   logic                         less [N][N];
   logic [wld_pkg::CMP_W-1:0]    gap;
   logic [wld_pkg::LIM_W-1:0]    limit;
   logic [wld_pkg::SUM_W-1:0]    sum;
   logic [wld_pkg::WL_W-1:0]     new_wl;

   assign rsp_data = rsp_ff;

   // Cross products: prod[a][b] = workload[a] * power[b]; pp = power[a] * power[b]
   always_comb begin
      for (int a = 0; a < N; a++) begin
         for (int b = 0; b < N; b++) begin
            prod_in[a][b] = (a == b) ? '0 :
               wld_pkg::PROD_W'(wl_ff[a]) *
               wld_pkg::PROD_W'(wld_pkg::eff_power(pwr_ff[b]));
            pp_in[a][b] = wld_pkg::PP_W'(wld_pkg::eff_power(pwr_ff[a])) *
                          wld_pkg::PP_W'(wld_pkg::eff_power(pwr_ff[b]));
         end
      end
   end

   // less[a][b]: load of a strictly below load of b
   always_comb begin
      for (int a = 0; a < N; a++) begin
         for (int b = 0; b < N; b++) begin
            less[a][b] = prod_ff[a][b] < prod_ff[b][a];
         end
      end
   end

   // Lowest and second lowest; lower index wins ties
   always_comb begin
      if (less[1][0]) begin
         first_in  = wld_pkg::PIDX_W'(1);
         second_in = wld_pkg::PIDX_W'(0);
      end else begin
         first_in  = wld_pkg::PIDX_W'(0);
         second_in = wld_pkg::PIDX_W'(1);
      end
      for (int i = 2; i < N; i++) begin
         if (less[i][first_in]) begin
            second_in = first_in;
            first_in  = wld_pkg::PIDX_W'(i);
         end else if (less[i][second_in]) begin
            second_in = wld_pkg::PIDX_W'(i);
         end
      end
   end

   // Gap between the two lowest loads against threshold * pf * ps
   always_comb begin
      gap = wld_pkg::CMP_W'(prod_ff[second_ff][first_ff]) -
            wld_pkg::CMP_W'(prod_ff[first_ff][second_ff]);
      limit = wld_pkg::LIM_W'(thr_ff) *
              wld_pkg::LIM_W'(pp_ff[first_ff][second_ff]);
      rr_sel_in = gap <= wld_pkg::CMP_W'(limit);
      chosen_in = rr_sel_in ? rr_ff : first_ff;
   end

   // Saturating workload update and response
   always_comb begin
      sum = wld_pkg::SUM_W'(wl_ff[chosen_ff]) + wld_pkg::SUM_W'(weight_ff);
      new_wl = (sum > wld_pkg::SUM_W'(WL_ALL_ONES)) ? WL_ALL_ONES
                                                     : wld_pkg::WL_W'(sum);
      rsp_in.chosen_proc    = wld_pkg::PROC_OUT_W'(chosen_ff);
      rsp_in.by_round_robin = rr_sel_ff;
      rsp_in.new_workload   = wld_pkg::RSP_WL_W'(new_wl);
      rsp_in.tag_out        = tag_ff;
   end

   // Configuration, workloads and pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N; i++) begin
            pwr_ff[i] <= wld_pkg::power_reset(i);
            wl_ff[i]  <= '0;
         end
         thr_ff <= wld_pkg::THRESHOLD_RESET;
         rr_ff  <= '0;
      end else begin
         if (csr_we) begin
            if (csr_addr < wld_pkg::CSR_ADDR_W'(N)) begin
               pwr_ff[csr_addr[wld_pkg::PIDX_W-1:0]] <= csr_wdata;
            end else if (csr_addr == wld_pkg::CSR_THRESHOLD) begin
               thr_ff <= csr_wdata;
            end
         end
         if (cmd.commit) begin
            wl_ff[chosen_ff] <= new_wl;
            if (rr_sel_ff) begin
               rr_ff <= (rr_ff == wld_pkg::PIDX_W'(N - 1)) ? '0 : rr_ff + 1'b1;
            end
         end
      end
   end

   // Per-task payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         weight_ff <= req_data.task_weight;
         tag_ff    <= req_data.task_tag;
         prod_ff   <= prod_in;
         pp_ff     <= pp_in;
      end
      if (cmd.rank) begin
         first_ff  <= first_in;
         second_ff <= second_in;
      end
      if (cmd.decide) begin
         rr_sel_ff <= rr_sel_in;
         chosen_ff <= chosen_in;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/wld_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wld_chk
// Port-level checks of the dispatcher, bound to the top level.
// ----------------------------------------------------------------------------
module wld_chk (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire wld_pkg::req_type  req_data,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire wld_pkg::rsp_type  rsp_data
);

   // Stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response beat changed while stalled");

   // One task at a time: busy for the cycles after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready ##1 !req_ready)
      else $error("request taken while a task is in flight");

   // A new response only appears at the end of a task
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("response raised while idle");

   // Reset leaves no response pending
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind weighted_least_load_dispatcher wld_chk u_wld_chk (.*);
`default_nettype wire

// File: tb/dispatch_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dispatch_checker
// Watches the request, response and register ports of the dispatcher, keeps
// its own copy of powers, threshold, workloads and round-robin pointer, and
// predicts the assignment of every accepted task. Responses are compared
// field by field, in order, with the oldest predicted assignment.
// ----------------------------------------------------------------------------
module dispatch_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   input  wire logic                            req_ready,
   input  wire wld_pkg::req_type                req_data,
   input  wire logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   input  wire wld_pkg::rsp_type                rsp_data,
   input  wire logic                            csr_we,
   input  wire logic [wld_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  wire logic [wld_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                                   fail_count,
   output int                                   pending
);
   import wld_pkg::*;

   localparam longint unsigned WORKLOAD_CEIL = (64'd1 << WL_W) - 1;
   localparam int MAX_REPORTS = 40;

   rsp_type           expected_assignments[$];
   logic [WL_W-1:0]   load_acc [NUM_PROCS];
   logic [PIDX_W-1:0] rr_ptr;
   logic [PWR_W-1:0]  power_cfg [NUM_PROCS];
   logic [PWR_W-1:0]  gap_limit;
   int                reports = 0;

   // zero power behaves as one
   function automatic longint unsigned nz_power(input int p);
      return (power_cfg[p] == '0) ? 64'd1 : 64'(power_cfg[p]);
   endfunction

   // strict "a carries less weighted load than b", by cross products
   function automatic bit lighter(input int a, input int b);
      longint unsigned la, lb;
      la = load_acc[a];
      lb = load_acc[b];
      return (la * nz_power(b)) < (lb * nz_power(a));
   endfunction

   // rank loads, pick a processor, update the model's state
   function automatic rsp_type predict_assignment(input req_type beat_in);
      int              lowest, runner, p, pick;
      longint unsigned pf, ps, wl_lo, wl_hi, gap, allowance, total;
      bit              fallback;
      rsp_type         r;
      if (lighter(1, 0)) begin
         lowest = 1;
         runner = 0;
      end else begin
         lowest = 0;
         runner = 1;
      end
      // lower index wins ties for both places
      for (p = 2; p < NUM_PROCS; p++) begin
         if (lighter(p, lowest)) begin
            runner = lowest;
            lowest = p;
         end else if (lighter(p, runner)) begin
            runner = p;
         end
      end
      pf        = nz_power(lowest);
      ps        = nz_power(runner);
      wl_lo     = load_acc[lowest];
      wl_hi     = load_acc[runner];
      gap       = wl_hi * pf - wl_lo * ps;
      allowance = 64'(gap_limit) * pf * ps;
      fallback  = (gap <= allowance);
      if (fallback) begin
         pick   = rr_ptr;
         rr_ptr = PIDX_W'((pick + 1) % NUM_PROCS);
      end else begin
         pick = lowest;
      end
      total = load_acc[pick];
      total = total + beat_in.task_weight;
      if (total > WORKLOAD_CEIL)
         total = WORKLOAD_CEIL;
      load_acc[pick]   = WL_W'(total);
      r.chosen_proc    = PROC_OUT_W'(pick);
      r.by_round_robin = fallback;
      r.new_workload   = RSP_WL_W'(total);
      r.tag_out        = beat_in.task_tag;
      return r;
   endfunction

   function automatic void check_field(input string name, input longint unsigned want,
                                       input longint unsigned got);
      if (want != got) begin
         fail_count++;
         if (reports < MAX_REPORTS)
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want,
                     got);
         reports++;
      end
   endfunction

   // one process: register writes, response compare, then prediction
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         // reset powers 2, 1, 3, 2
         power_cfg[0] = 8'd2;
         power_cfg[1] = 8'd1;
         power_cfg[2] = 8'd3;
         power_cfg[3] = 8'd2;
         gap_limit    = THRESHOLD_RESET;
         for (int p = 0; p < NUM_PROCS; p++)
            load_acc[p] = '0;
         rr_ptr = '0;
         expected_assignments.delete();
      end else begin
         if (csr_we === 1'b1) begin
            if (csr_addr < CSR_THRESHOLD)
               power_cfg[csr_addr - CSR_POWER_0] = csr_wdata;
            else if (csr_addr == CSR_THRESHOLD)
               gap_limit = csr_wdata;
         end
         if (rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
            if (expected_assignments.size() == 0) begin
               fail_count++;
               if (reports < MAX_REPORTS)
                  $display("%0t: response with no task outstanding, expected none, actual 0x%0h",
                           $time, rsp_data);
               reports++;
            end else begin
               want = expected_assignments.pop_front();
               check_field("chosen_proc", want.chosen_proc, rsp_data.chosen_proc);
               check_field("by_round_robin", want.by_round_robin, rsp_data.by_round_robin);
               check_field("new_workload", want.new_workload, rsp_data.new_workload);
               check_field("tag_out", want.tag_out, rsp_data.tag_out);
            end
         end
         if (req_valid === 1'b1 && req_ready === 1'b1)
            expected_assignments.push_back(predict_assignment(req_data));
      end
      pending <= expected_assignments.size();
   end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the weighted least-load dispatcher. A directed
// opening covers weight and tag extremes, load ties, zero and full powers and
// both thresholds; random phases follow under varied register settings and
// sender/receiver idling, including a long response hold-off and a phase
// that drives one processor's workload into saturation.
// ----------------------------------------------------------------------------
module tb;
   import wld_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 120;
   localparam int PHASES       = 9;
   localparam int SAT_PHASE    = 5;
   localparam int PHASE_TASKS  = 200;
   localparam int SAT_TASKS    = 320;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int          fail_count;
   int          pending;
   int          idle_pct    = 0;
   int          stall_pct   = 0;
   int          hold_req    = 0;
   int          hold_ack    = 0;
   int          hold_left   = 0;
   int unsigned cycle_count = 0;

   always #2 clock = ~clock;

   weighted_least_load_dispatcher dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   dispatch_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // receiver: random stalls, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_req != hold_ack) begin
         hold_ack  <= hold_req;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // offer one beat, with random idle cycles ahead of it
   task automatic send_item(input req_type beat_in);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat_in;
      do @(posedge clock); while (req_ready !== 1'b1);
   endtask

   // stop offering and wait until every predicted response has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
   endtask

   // write all five registers, then one write to an unmapped index
   task automatic program_regs(input logic [PWR_W-1:0] p0, input logic [PWR_W-1:0] p1,
                               input logic [PWR_W-1:0] p2, input logic [PWR_W-1:0] p3,
                               input logic [PWR_W-1:0] thr);
      logic [PWR_W-1:0] vals [5];
      vals = '{p0, p1, p2, p3, thr};
      for (int i = 0; i < 6; i++) begin
         csr_we <= 1'b1;
         if (i < 4) begin
            csr_addr  <= CSR_POWER_0 + CSR_ADDR_W'(i);
            csr_wdata <= vals[i];
         end else if (i == 4) begin
            csr_addr  <= CSR_THRESHOLD;
            csr_wdata <= vals[4];
         end else begin
            csr_addr  <= CSR_THRESHOLD + CSR_ADDR_W'($urandom_range(1, 3));
            csr_wdata <= CSR_DATA_W'($urandom);
         end
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   function automatic logic [PWR_W-1:0] rand_power();
      case ($urandom_range(9))
         0:       return '0;
         1, 2:    return 8'd1;
         3:       return 8'd255;
         default: return PWR_W'($urandom_range(1, 255));
      endcase
   endfunction

   initial begin
      logic [PWR_W-1:0]    thr;
      logic [WEIGHT_W-1:0] w;
      int                  n;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings: all-zero ties, then extremes of weight and tag
      send_item('{16'h0000, 8'h00});
      send_item('{16'hFFFF, 8'hFF});
      send_item('{16'h0001, 8'h01});
      send_item('{16'h8000, 8'h80});
      send_item('{16'h7FFF, 8'h7F});
      send_item('{16'hFFFF, 8'hAA});
      send_item('{16'h0000, 8'h55});
      send_item('{16'h00FF, 8'h0F});
      send_item('{16'hFF00, 8'hF0});
      send_item('{16'hFFFF, 8'hFF});
      send_item('{16'h0002, 8'h02});
      wait_drained();

      // zero powers count as one, zero threshold
      program_regs(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      send_item('{16'h0000, 8'h00});
      send_item('{16'h0000, 8'h11});
      send_item('{16'hFFFF, 8'hFF});
      send_item('{16'h1234, 8'h34});
      send_item('{16'hFFFF, 8'hC3});
      send_item('{16'h0000, 8'h3C});
      wait_drained();

      // full powers, widest threshold
      program_regs(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
      send_item('{16'hFFFF, 8'hFF});
      send_item('{16'hFFFF, 8'h00});
      send_item('{16'h0001, 8'h81});
      send_item('{16'h0000, 8'h7E});
      wait_drained();

      // random phases
      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph != 0)
            wait_drained();
         if (ph == SAT_PHASE) begin
            // processor zero takes nearly all weight and saturates
            program_regs(8'd255, 8'd1, 8'd1, 8'd1, 8'd0);
         end else begin
            case ($urandom_range(4))
               0:       thr = '0;
               1:       thr = 8'd255;
               2:       thr = PWR_W'($urandom_range(1, 8));
               default: thr = PWR_W'($urandom_range(255));
            endcase
            program_regs(rand_power(), rand_power(), rand_power(), rand_power(), thr);
         end
         case (ph % 4)
            0: begin
               idle_pct = 0;
               stall_pct <= 0;
            end
            1: begin
               idle_pct = 58;
               stall_pct <= 0;
            end
            2: begin
               idle_pct = 0;
               stall_pct <= 58;
            end
            default: begin
               idle_pct = 38;
               stall_pct <= 38;
            end
         endcase
         // long response hold-off while the sender keeps offering
         if (ph == 0 || ph == 6)
            hold_req <= hold_req + 1;
         n = (ph == SAT_PHASE) ? SAT_TASKS : PHASE_TASKS;
         for (int k = 0; k < n; k++) begin
            if (ph == SAT_PHASE) begin
               w = WEIGHT_W'($urandom_range(16'hF000, 16'hFFFF));
            end else begin
               case ($urandom_range(19))
                  0, 1, 2:    w = '0;
                  3, 4, 5:    w = '1;
                  6, 7, 8, 9,
                  10, 11:     w = WEIGHT_W'($urandom_range(255));
                  default:    w = WEIGHT_W'($urandom);
               endcase
            end
            send_item('{w, TAG_W'($urandom)});
         end
      end
      wait_drained();

      repeat (16) @(posedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/wld_pkg.sv
hw/rtl/wld_ctrl.sv
hw/rtl/wld_dp.sv
hw/rtl/weighted_least_load_dispatcher.sv
hw/rtl/wld_chk.sv
tb/dispatch_checker.sv
tb/tb.sv
